/* rtl/lmd3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd3_pkg: shared definitions for the 3x3 local minimum detector
// widths, frame limits, register indexes and result slot codes
// ----------------------------------------------------------------------------
package lmd3_pkg;

   localparam int PIXEL_W    = 8;
   localparam int COORD_W    = 10;
   localparam int CFG_W      = 11;
   localparam int COUNT_W    = 21;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);

   localparam logic [CFG_W-1:0] DIM_MIN        = CFG_W'(2);
   localparam logic [CFG_W-1:0] WIDTH_MAX      = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_MAX     = CFG_W'(MAX_HEIGHT);
   localparam logic [CFG_W-1:0] WIDTH_RESET    = CFG_W'(10);
   localparam logic [CFG_W-1:0] HEIGHT_RESET   = CFG_W'(10);

   // register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // result slots of one pixel, in emission order
   localparam int SLOT_INNER  = 0;   // center one row up, one column left
   localparam int SLOT_RIGHT  = 1;   // right edge center one row up
   localparam int SLOT_BOTTOM = 2;   // last row center one column left
   localparam int SLOT_CORNER = 3;   // bottom right corner
   localparam int SLOTS       = 4;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [2:0][2:0] window_type;

   // per-pixel context carried through the pipeline
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [SLOTS-1:0]   slots;
      logic               top_ok;    // row two up exists
      logic               left_ok;   // column two left exists
   } ctx_type;

endpackage

/* rtl/local_minimum_detector_3x3_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_minimum_detector_3x3_top: 3x3 local minimum detector
// raster pixel stream in, one judged center pixel per result transfer out
// ----------------------------------------------------------------------------
// usage
//   req channel: one pixel per transfer (req_valid high, req_stall low) in
//   raster order. rsp channel: one judged center pixel per transfer, with
//   position, minimum flag, marked value and running minima count.
//   a pixel causes 0 to 4 results: one for the center up and left once past
//   the first row and column, one more at the right edge, and the last row
//   adds its own centers; rsp_last_of_run closes the results of one pixel.
//   the first result of a pixel passes the line buffer read, the window
//   stage and the output register, in that order.
//   throughput: one pixel per cycle while each pixel causes at most one
//   result and rsp_stall is low; a pixel with more results holds the window
//   stage while the single output register drains one result per cycle.
//   csr writes (frame_width, frame_height) restart the frame; the user makes
//   them only while the block is idle (not enforced). widths clamp to 2..1024.
//   reset: synchronous, clears counters, window and valids; configuration
//   returns to 10 x 10. line buffers are not cleared: entries never written
//   are never compared since only neighbors inside the frame count.
//   rsp_stall holds the output register, then the window stage, then
//   raises req_stall; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module local_minimum_detector_3x3_top
   import lmd3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_en,
   input  logic [0:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   // pixel input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PIXEL_W-1:0]  req_pixel,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_row,
   output logic [COORD_W-1:0]  rsp_column,
   output logic                rsp_is_minimum,
   output logic [PIXEL_W-1:0]  rsp_marked_value,
   output logic [COUNT_W-1:0]  rsp_minima_count,
   output logic                rsp_last_of_run,
   output logic                rsp_end_of_frame
);

   // configuration and frame position
   logic [CFG_W-1:0]    width_ff, width_in;
   logic [CFG_W-1:0]    height_ff, height_in;
   logic [CFG_W-1:0]    width_used, height_used;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic [COUNT_W-1:0]  total_ff, total_in;

   // line buffers
   pixel_type           older_row_store [MAX_WIDTH];
   pixel_type           newer_row_store [MAX_WIDTH];
   pixel_type           older_rd_ff;
   pixel_type           newer_rd_ff;

   // read stage
   logic                s1_valid_ff;
   pixel_type           s1_pixel_ff;
   ctx_type             s1_ctx_ff;
   ctx_type             acc_ctx;

   // window stage
   logic                s2_valid_ff, s2_valid_in;
   ctx_type             s2_ctx_ff;
   logic [SLOTS-1:0]    s2_slots_ff, s2_slots_in;
   window_type          win_ff, win_in;

   // output register
   logic                rsp_valid_ff;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [COORD_W-1:0]  rsp_col_ff;
   logic                rsp_min_ff;
   pixel_type           rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;
   logic                rsp_eof_ff;

   // handshake and flow
   logic                req_xfer;
   logic                out_free;
   logic                emit;
   logic                s2_done;
   logic                s2_load_ok;
   logic                s1_move;

   // judge of the selected slot
   logic [SLOTS-1:0]    sel;
   logic [SLOTS-1:0]    slots_left;
   logic                inner_row, inner_col;
   logic [1:0]          cen_r, cen_c;
   logic                top_ok, bot_ok, left_ok, right_ok;
   pixel_type           center;
   logic                is_min;
   logic [COORD_W-1:0]  judge_row, judge_col;
   logic                judge_eof;
   logic [COUNT_W-1:0]  count_next;

   // ---------------------------------------------------------------------
   // effective frame size
   // ---------------------------------------------------------------------
   always_comb begin
      if (width_ff < DIM_MIN) begin
         width_used = DIM_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_used = WIDTH_MAX;
      end else begin
         width_used = width_ff;
      end
      if (height_ff < DIM_MIN) begin
         height_used = DIM_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         height_used = HEIGHT_MAX;
      end else begin
         height_used = height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // flow control: output register, window stage, read stage
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = s2_valid_ff && out_free;
   assign slots_left = s2_slots_ff & ~sel;
   assign s2_done    = emit && (slots_left == '0);
   assign s2_load_ok = !s2_valid_ff || s2_done;
   assign s1_move    = s1_valid_ff && s2_load_ok;
   assign req_stall  = s1_valid_ff && !s2_load_ok;
   assign req_xfer   = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // result slots of the incoming pixel, from its frame position
   // ---------------------------------------------------------------------
   always_comb begin
      logic row_any, col_any, row_last, col_last;
      row_any  = (row_ff != '0);
      col_any  = (col_ff != '0);
      row_last = ({1'b0, row_ff} == height_used - CFG_W'(1));
      col_last = ({1'b0, col_ff} == width_used - CFG_W'(1));
      acc_ctx.row                 = row_ff;
      acc_ctx.col                 = col_ff;
      acc_ctx.slots[SLOT_INNER]   = row_any && col_any;
      acc_ctx.slots[SLOT_RIGHT]   = row_any && col_last;
      acc_ctx.slots[SLOT_BOTTOM]  = row_last && col_any;
      acc_ctx.slots[SLOT_CORNER]  = row_last && col_last;
      acc_ctx.top_ok              = (row_ff > COORD_W'(1));
      acc_ctx.left_ok             = (col_ff > COORD_W'(1));
   end

   // ---------------------------------------------------------------------
   // configuration and frame counters
   // ---------------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      total_in  = total_ff;
      // result accounting; the frame's last result restarts the count
      if (emit) begin
         total_in = judge_eof ? '0 : count_next;
      end
      // raster position advances on each pixel transfer
      if (req_xfer) begin
         if ({1'b0, col_ff} + CFG_W'(1) < width_used) begin
            col_in = col_ff + COORD_W'(1);
         end else if ({1'b0, row_ff} + CFG_W'(1) < height_used) begin
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = '0;
            row_in = '0;
         end
      end
      // any register write restarts the frame
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
         row_in   = '0;
         col_in   = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         total_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         total_ff  <= total_in;
      end
   end

   // ---------------------------------------------------------------------
   // line buffers: read on transfer, shift column while in the read stage
   // consecutive pixels never share a column, so read and write never collide
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         older_rd_ff <= older_row_store[col_ff];
         newer_rd_ff <= newer_row_store[col_ff];
      end
      if (s1_valid_ff) begin
         older_row_store[s1_ctx_ff.col] <= newer_rd_ff;
         newer_row_store[s1_ctx_ff.col] <= s1_pixel_ff;
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_ff <= req_pixel;
         s1_ctx_ff   <= acc_ctx;
      end
   end

   // ---------------------------------------------------------------------
   // window stage: shift in the new column, then work through the slots
   // ---------------------------------------------------------------------
   always_comb begin
      win_in      = win_ff;
      s2_valid_in = s2_valid_ff;
      s2_slots_in = s2_slots_ff;
      if (s1_move) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = older_rd_ff;
         win_in[1][2] = newer_rd_ff;
         win_in[2][2] = s1_pixel_ff;
         // a pixel with no results only moves the window
         s2_valid_in  = (s1_ctx_ff.slots != '0);
         s2_slots_in  = s1_ctx_ff.slots;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end else if (emit) begin
         s2_slots_in = slots_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_slots_ff <= s2_slots_in;
      if (s1_move) begin
         s2_ctx_ff <= s1_ctx_ff;
      end
   end

   // ---------------------------------------------------------------------
   // judge the lowest pending slot
   // ---------------------------------------------------------------------
   assign sel = s2_slots_ff & (~s2_slots_ff + SLOTS'(1));

   assign inner_row = sel[SLOT_INNER] || sel[SLOT_RIGHT];
   assign inner_col = sel[SLOT_INNER] || sel[SLOT_BOTTOM];
   assign cen_r     = inner_row ? 2'd1 : 2'd2;
   assign cen_c     = inner_col ? 2'd1 : 2'd2;
   // a center one row up always has the newest row below it; a last row
   // center has none. same for columns
   assign top_ok    = inner_row ? s2_ctx_ff.top_ok : 1'b1;
   assign bot_ok    = inner_row;
   assign left_ok   = inner_col ? s2_ctx_ff.left_ok : 1'b1;
   assign right_ok  = inner_col;
   assign center    = win_ff[cen_r][cen_c];

   always_comb begin
      logic [1:0] pr;
      logic [1:0] pc;
      logic       near, in_frame;
      is_min = 1'b1;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pr       = 2'(r);
            pc       = 2'(c);
            near     = !((cen_r == 2'd2) && (pr == 2'd0))
                       && !((cen_c == 2'd2) && (pc == 2'd0))
                       && !((pr == cen_r) && (pc == cen_c));
            in_frame = ((pr < cen_r) ? top_ok : 1'b1)
                       && ((pr > cen_r) ? bot_ok : 1'b1)
                       && ((pc < cen_c) ? left_ok : 1'b1)
                       && ((pc > cen_c) ? right_ok : 1'b1);
            if (near && in_frame) begin
               if (!(center < win_ff[r][c])) begin
                  is_min = 1'b0;
               end
            end
         end
      end
   end

   assign judge_row  = inner_row ? s2_ctx_ff.row - COORD_W'(1) : s2_ctx_ff.row;
   assign judge_col  = inner_col ? s2_ctx_ff.col - COORD_W'(1) : s2_ctx_ff.col;
   assign judge_eof  = sel[SLOT_CORNER];
   assign count_next = total_ff + COUNT_W'(is_min);

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= judge_row;
         rsp_col_ff   <= judge_col;
         rsp_min_ff   <= is_min;
         rsp_value_ff <= is_min ? center : '0;
         rsp_count_ff <= count_next;
         rsp_last_ff  <= (slots_left == '0);
         rsp_eof_ff   <= judge_eof;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_column       = rsp_col_ff;
   assign rsp_is_minimum   = rsp_min_ff;
   assign rsp_marked_value = rsp_value_ff;
   assign rsp_minima_count = rsp_count_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // the frame's last result always closes its pixel's run
   a_eof_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> rsp_last_ff)
      else $error("end of frame result without last_of_run");

   // a busy window stage always has a result left to send
   a_s2_has_work: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_slots_ff != '0))
      else $error("window stage valid with no pending slot");

   // the count restarts after the frame's last result
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      emit && judge_eof && !csr_write_en |=> (total_ff == '0))
      else $error("minima count not cleared at end of frame");

   // input stalls only while the read stage holds a pixel
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff)
      else $error("input stalled with free pipeline");
`endif

endmodule

/* dv/local_minimum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_minimum_checker: result prediction and comparison for the 3x3 detector
// follows csr writes and pixel transfers, predicts every judged center pixel
// and compares each result transfer, field by field, with the oldest one due
// ----------------------------------------------------------------------------
module local_minimum_checker
   import lmd3_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [COORD_W-1:0] rsp_row,
   input  logic [COORD_W-1:0] rsp_column,
   input  logic               rsp_is_minimum,
   input  logic [PIXEL_W-1:0] rsp_marked_value,
   input  logic [COUNT_W-1:0] rsp_minima_count,
   input  logic               rsp_last_of_run,
   input  logic               rsp_end_of_frame,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic               is_minimum;
      logic [PIXEL_W-1:0] marked_value;
      logic [COUNT_W-1:0] minima_count;
      logic               last_of_run;
      logic               end_of_frame;
   } center_result_type;

   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   pixel_type          older_line [MAX_WIDTH];
   pixel_type          newer_line [MAX_WIDTH];
   pixel_type          win [3][3];
   int                 at_row;
   int                 at_col;
   logic [COUNT_W-1:0] minima_seen;
   center_result_type  centers_due [$];

   function automatic int clamp_dim(logic [CFG_W-1:0] value, int limit);
      if (value < DIM_MIN) return 2;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   function automatic void restart_frame();
      at_row      = 0;
      at_col      = 0;
      minima_seen = '0;
   endfunction

   // center held at window (wr, wc) sits at frame position (rr, cc)
   function automatic center_result_type judge_center(int wr, int wc, int rr, int cc,
                                                      int w, int h);
      center_result_type res;
      pixel_type         center;
      logic              below_all;
      center    = win[wr][wc];
      below_all = 1'b1;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && rr + dr >= 0 && rr + dr < h
                && cc + dc >= 0 && cc + dc < w
                && wr + dr >= 0 && wr + dr <= 2 && wc + dc >= 0 && wc + dc <= 2) begin
               if (!(center < win[wr+dr][wc+dc])) below_all = 1'b0;
            end
         end
      end
      if (below_all) minima_seen = minima_seen + COUNT_W'(1);
      res.row          = COORD_W'(rr);
      res.column       = COORD_W'(cc);
      res.is_minimum   = below_all;
      res.marked_value = below_all ? center : '0;
      res.minima_count = minima_seen;
      res.last_of_run  = 1'b0;
      res.end_of_frame = (rr == h - 1 && cc == w - 1);
      return res;
   endfunction

   task automatic take_pixel(pixel_type value);
      center_result_type found [SLOTS];
      int w;
      int h;
      int count;
      w     = clamp_dim(width_reg, MAX_WIDTH);
      h     = clamp_dim(height_reg, MAX_HEIGHT);
      count = 0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2]          = older_line[at_col];
      win[1][2]          = newer_line[at_col];
      win[2][2]          = value;
      older_line[at_col] = newer_line[at_col];
      newer_line[at_col] = value;
      // inner, right edge, last row, corner
      if (at_row >= 1 && at_col >= 1) begin
         found[count] = judge_center(1, 1, at_row - 1, at_col - 1, w, h);
         count++;
      end
      if (at_row >= 1 && at_col == w - 1) begin
         found[count] = judge_center(1, 2, at_row - 1, at_col, w, h);
         count++;
      end
      if (at_row == h - 1 && at_col >= 1) begin
         found[count] = judge_center(2, 1, at_row, at_col - 1, w, h);
         count++;
      end
      if (at_row == h - 1 && at_col == w - 1) begin
         found[count] = judge_center(2, 2, at_row, at_col, w, h);
         count++;
      end
      if (count > 0) found[count-1].last_of_run = 1'b1;
      for (int i = 0; i < count; i++) centers_due.push_back(found[i]);
      if (at_col + 1 < w) begin
         at_col++;
      end else if (at_row + 1 < h) begin
         at_col = 0;
         at_row++;
      end else begin
         restart_frame();
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      center_result_type want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
         restart_frame();
         centers_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (centers_due.size() == 0) begin
               $error("result transfer at row %0d column %0d with nothing due",
                      rsp_row, rsp_column);
               fail_count++;
            end else begin
               want = centers_due.pop_front();
               check_field("row", 32'(want.row), 32'(rsp_row));
               check_field("column", 32'(want.column), 32'(rsp_column));
               check_field("is_minimum", 32'(want.is_minimum), 32'(rsp_is_minimum));
               check_field("marked_value", 32'(want.marked_value),
                           32'(rsp_marked_value));
               check_field("minima_count", 32'(want.minima_count),
                           32'(rsp_minima_count));
               check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
               check_field("end_of_frame", 32'(want.end_of_frame),
                           32'(rsp_end_of_frame));
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg  = csr_wdata;
               CSR_FRAME_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
            restart_frame();
         end
         if (req_valid && !req_stall) take_pixel(req_pixel);
      end
      pending = centers_due.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the 3x3 local minimum detector
// streams pixel frames under several geometries with random idling on both
// channels; a separate checker predicts and compares every result transfer
// ----------------------------------------------------------------------------
module tb_top;
   import lmd3_pkg::*;

   localparam int RANDOM_PIXELS = 45;
   localparam int SETTLE_CYCLES = 8;    // pipeline is three stages deep, leave margin
   localparam int LONG_LINE     = 24;   // pixels sent in the widest and tallest frames

   // 2x2 frames: corner minimum against maximal neighbors, all ties,
   // and a descending frame whose last pixel causes all four results
   localparam logic [11:0][PIXEL_W-1:0] TWO_BY_TWO = {
      8'd0,   8'd255, 8'd255, 8'd255,
      8'd9,   8'd9,   8'd9,   8'd9,
      8'd200, 8'd100, 8'd50,  8'd1
   };
   // 3x3 frame with a strict minimum in the middle and edge ties around it
   localparam logic [8:0][PIXEL_W-1:0] THREE_BY_THREE = {
      8'd90, 8'd80, 8'd90,
      8'd80, 8'd5,  8'd80,
      8'd90, 8'd80, 8'd90
   };

   logic               clock;
   logic               reset        = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [0:0]         csr_index    = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0]   csr_wdata    = '0;
   logic               req_valid    = 1'b0;
   logic               req_stall;
   logic [PIXEL_W-1:0] req_pixel    = '0;
   logic               rsp_valid;
   logic               rsp_stall    = 1'b0;
   logic [COORD_W-1:0] rsp_row;
   logic [COORD_W-1:0] rsp_column;
   logic               rsp_is_minimum;
   logic [PIXEL_W-1:0] rsp_marked_value;
   logic [COUNT_W-1:0] rsp_minima_count;
   logic               rsp_last_of_run;
   logic               rsp_end_of_frame;
   int                 fail_count;
   int                 pending;

   // idling switches for the pixel sender and the result receiver
   bit                 sender_idles;
   bit                 receiver_idles;

   local_minimum_detector_3x3_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_column       (rsp_column),
      .rsp_is_minimum   (rsp_is_minimum),
      .rsp_marked_value (rsp_marked_value),
      .rsp_minima_count (rsp_minima_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   local_minimum_checker minimum_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_column       (rsp_column),
      .rsp_is_minimum   (rsp_is_minimum),
      .rsp_marked_value (rsp_marked_value),
      .rsp_minima_count (rsp_minima_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // 10 ns clock, first rising edge at 5 ns
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver stalls about a quarter of the cycles while idling is on
   always @(negedge clock) begin
      rsp_stall <= receiver_idles && ($urandom_range(99) < 24);
   end

   // one pixel transfer; entered and left at a falling edge with req_valid
   // still high, so a following transfer keeps valid up without a glitch
   task automatic send_pixel(logic [PIXEL_W-1:0] value);
      while (sender_idles && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         req_pixel <= PIXEL_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // drop valid and wait until every predicted result has been taken,
   // then let the pipeline settle as long as the settle argument sets
   task automatic hold_off(int settle);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // write both geometry registers; each write restarts the frame
   task automatic set_frame(logic [CFG_W-1:0] width_val, logic [CFG_W-1:0] height_val);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FRAME_WIDTH;
      csr_wdata    <= width_val;
      @(negedge clock);
      csr_index    <= CSR_FRAME_HEIGHT;
      csr_wdata    <= height_val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int               random_sent;
      int               burst;
      logic [CFG_W-1:0] width_val;
      logic [CFG_W-1:0] height_val;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry 10x10: one full frame and the start of the next,
      // with one full drain in the middle of a row
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (int i = 0; i < 105; i++) begin
         if (i == 47) hold_off(0);
         send_pixel(PIXEL_W'($urandom_range(255)));
         random_sent++;
      end

      // both registers below range clamp up to the smallest 2x2 frame;
      // three frames back to back cross the end of frame without a write
      hold_off(SETTLE_CYCLES);
      set_frame(CFG_W'(0), CFG_W'(1));
      for (int i = 11; i >= 0; i--) send_pixel(TWO_BY_TWO[i]);

      hold_off(SETTLE_CYCLES);
      set_frame(CFG_W'(3), CFG_W'(3));
      for (int i = 8; i >= 0; i--) send_pixel(THREE_BY_THREE[i]);

      // all-ones width clamps to the widest line; long stretch with no
      // idling through the start of that line and the tall frame below
      hold_off(SETTLE_CYCLES);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_frame({CFG_W{1'b1}}, CFG_W'(2));
      for (int i = 0; i < LONG_LINE; i++) send_pixel(PIXEL_W'($urandom_range(255)));

      // narrowest width with the tallest height taken exactly
      hold_off(SETTLE_CYCLES);
      set_frame(CFG_W'(2), HEIGHT_MAX);
      for (int i = 0; i < LONG_LINE; i++) begin
         send_pixel((i % 2 == 0) ? PIXEL_W'($urandom_range(255))
                                 : PIXEL_W'($urandom_range(3)));
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;

      // small random geometries, whole and partial frames, narrow value
      // ranges mixed in so that ties and minima both show up often
      while (random_sent < RANDOM_PIXELS + 105) begin
         width_val  = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(1))
                                               : CFG_W'($urandom_range(2, 9));
         height_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(1))
                                               : CFG_W'($urandom_range(2, 9));
         burst      = $urandom_range(4, 24);
         hold_off(SETTLE_CYCLES);
         set_frame(width_val, height_val);
         repeat (burst) begin
            if ($urandom_range(99) < 3) hold_off(0);
            send_pixel($urandom_range(1) ? PIXEL_W'($urandom_range(255))
                                         : PIXEL_W'(100 + $urandom_range(3)));
            random_sent++;
         end
      end

      // drain and let any stray result show up before the verdict
      hold_off(SETTLE_CYCLES + 2);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #6ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
rtl/lmd3_pkg.sv
rtl/local_minimum_detector_3x3_top.sv
dv/local_minimum_checker.sv
dv/tb_top.sv
